@@ src/desrf_pkg.sv @@
package desrf_pkg;

  localparam int unsigned HalfW = 32;
  localparam int unsigned ExpW  = 48;
  localparam int unsigned NumSbox = 8;

  typedef logic [HalfW-1:0] half_t;
  typedef logic [ExpW-1:0]  exp_t;

  // Expansion table, DES numbering (1 = MSB)
  localparam logic [5:0] ETab [ExpW] = '{
    6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
    6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
    6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
  };

  localparam logic [5:0] PTab [HalfW] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  localparam logic [3:0] STab [NumSbox][4][16] = '{
    '{'{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7},
      '{4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8},
      '{4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0},
      '{4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13}},
    '{'{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10},
      '{4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5},
      '{4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15},
      '{4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9}},
    '{'{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8},
      '{4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1},
      '{4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7},
      '{4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12}},
    '{'{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15},
      '{4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9},
      '{4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4},
      '{4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14}},
    '{'{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9},
      '{4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6},
      '{4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14},
      '{4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3}},
    '{'{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11},
      '{4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8},
      '{4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6},
      '{4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13}},
    '{'{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1},
      '{4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6},
      '{4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2},
      '{4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12}},
    '{'{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7},
      '{4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2},
      '{4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8},
      '{4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}}
  };

  // DES bit n (1 = MSB) of a half word sits at index HalfW - n
  function automatic exp_t expand(input half_t r);
    exp_t x;
    for (int i = 0; i < ExpW; i++) begin
      x[ExpW-1-i] = r[HalfW - int'(ETab[i])];
    end
    return x;
  endfunction

  function automatic half_t permute(input half_t s);
    half_t p;
    for (int i = 0; i < HalfW; i++) begin
      p[HalfW-1-i] = s[HalfW - int'(PTab[i])];
    end
    return p;
  endfunction

  // Row from the outer bits, column from the middle four
  function automatic logic [3:0] sbox(input logic [2:0] n, input logic [5:0] g);
    return STab[n][{g[5], g[0]}][g[4:1]];
  endfunction

endpackage

@@ src/desrf_expand.sv @@
module desrf_expand import desrf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  half_t right_half_i,
  input  exp_t  round_key_i,
  output logic  valid_o,
  input  logic  ready_i,
  output exp_t  x_o
);

  logic valid_q;
  exp_t x_q;
  exp_t x_d;

  assign ready_o = !valid_q || ready_i;
  assign x_d     = expand(right_half_i) ^ round_key_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      x_q <= x_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;

endmodule

@@ src/desrf_sbox.sv @@
module desrf_sbox import desrf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  exp_t  x_i,
  output logic  valid_o,
  input  logic  ready_i,
  output half_t s_o
);

  logic  valid_q;
  half_t s_q;
  half_t s_d;

  assign ready_o = !valid_q || ready_i;

  // Group 0 takes the top six bits and lands in the top nibble
  always_comb begin
    for (int i = 0; i < NumSbox; i++) begin
      s_d[HalfW-1-4*i -: 4] = sbox(3'(i), x_i[ExpW-1-6*i -: 6]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      s_q <= s_d;
    end
  end

  assign valid_o = valid_q;
  assign s_o     = s_q;

endmodule

@@ src/desrf_perm.sv @@
module desrf_perm import desrf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  half_t s_i,
  output logic  valid_o,
  input  logic  ready_i,
  output half_t f_o
);

  logic  valid_q;
  half_t f_q;
  half_t f_d;

  assign ready_o = !valid_q || ready_i;
  assign f_d     = permute(s_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      f_q <= f_d;
    end
  end

  assign valid_o = valid_q;
  assign f_o     = f_q;

endmodule

@@ src/des_round_function_unit.sv @@
// DES round function f: E expansion and key mix, S-box lookup, P permutation.
//
// Input channel: in_valid_i with right_half_i and round_key_i; the block
// holds in_stall_o high when it cannot take the beat. A beat is taken at a
// rising edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o with f_result_o; the receiver stalls with
// out_stall_i. A beat leaves at an edge with out_valid_o high and
// out_stall_i low.
// Three register stages, one each for expansion/key XOR, the eight
// S-boxes and the P permutation. One beat per cycle is taken
// when the output is not stalled.
// A stall on the output holds the last stage; earlier stages keep filling
// their empty slots, and in_stall_o rises only once all three stages hold
// a beat and the receiver stalls.
// Reset (rst_ni low, asynchronous) empties all stages; the data registers are not reset.
module des_round_function_unit import desrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] right_half_i,
  input  logic [47:0] round_key_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] f_result_o
);

  logic  v1, v2, v3;
  logic  rdy1, rdy2, rdy3;
  exp_t  x1;
  half_t s2;
  half_t f3;

  desrf_expand u_expand (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_valid_i),
    .ready_o      (rdy1),
    .right_half_i (right_half_i),
    .round_key_i  (round_key_i),
    .valid_o      (v1),
    .ready_i      (rdy2),
    .x_o          (x1)
  );

  desrf_sbox u_sbox (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .ready_o (rdy2),
    .x_i     (x1),
    .valid_o (v2),
    .ready_i (rdy3),
    .s_o     (s2)
  );

  desrf_perm u_perm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2),
    .ready_o (rdy3),
    .s_i     (s2),
    .valid_o (v3),
    .ready_i (!out_stall_i),
    .f_o     (f3)
  );

  assign in_stall_o  = !rdy1;
  assign out_valid_o = v3;
  assign f_result_o  = f3;

endmodule

@@ src/desrf_checker.sv @@
module desrf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] f_result_o
);

  // Back-pressure only reaches the input when the output is held
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output stall");

  // With a free receiver a beat comes out once it has passed the expansion, S-box and permutation stages
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_stall_i) ##1 !out_stall_i ##1 !out_stall_i
      |=> out_valid_o)
    else $error("result missing after pipeline latency");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output valid dropped under stall");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(f_result_o))
    else $error("output beat changed under stall");

endmodule

bind des_round_function_unit desrf_checker u_desrf_checker (.*);

@@ test/des_round_function_unit_test.sv @@
module des_round_function_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DirectedItems = 16;
  localparam int unsigned RandomItems   = 1830;
  localparam int unsigned MaxReported   = 10;

  // One S-box row per entry, column c in nibble c counted from the top; entry 4*box + row
  localparam logic [63:0] SboxRows [32] = '{
    64'hE4D12FB83A6C5907, 64'h0F74E2D1A6CB9538, 64'h41E8D62BFC973A50, 64'hFC8249175B3EA06D,
    64'hF18E6B34972DC05A, 64'h3D47F28EC01A69B5, 64'h0E7BA4D158C6932F, 64'hD8A13F42B67C05E9,
    64'hA09E63F51DC7B428, 64'hD709346A285ECBF1, 64'hD6498F30B12C5AE7, 64'h1AD069874FE3B52C,
    64'h7DE3069A1285BC4F, 64'hD8B56F03472C1AE9, 64'hA690CB7DF13E5284, 64'h3F06A1D8945BC72E,
    64'h2C417AB6853FD0E9, 64'hEB2C47D150FA3986, 64'h421BAD78F9C5630E, 64'hB8C71E2D6F09A453,
    64'hC1AF92680D34E75B, 64'hAF427C9561DE0B38, 64'h9EF528C3704A1DB6, 64'h432C95FABE17608D,
    64'h4B2EF08D3C975A61, 64'hD0B7491AE35C2F86, 64'h14BDC37EAF680592, 64'h6BD814A7950FE23C,
    64'hD2846FB1A93E50C7, 64'h1FD8A374C56B0E92, 64'h7B419CE206ADF358, 64'h21E74A8DFC90356B
  };

  // Output bit i (from the top) takes DES bit PermSrc[i] of the S-box word
  localparam int unsigned PermSrc [32] = '{
    16, 7, 20, 21, 29, 12, 28, 17, 1, 15, 23, 26, 5, 18, 31, 10,
    2, 8, 24, 14, 32, 27, 3, 9, 19, 13, 30, 6, 22, 11, 4, 25
  };

  localparam logic [31:0] DirRight [DirectedItems] = '{
    32'h00000000, 32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF,
    32'h00000000, 32'h00000000, 32'h55555555, 32'hAAAAAAAA,
    32'h80000000, 32'h00000001, 32'h80000001, 32'hF0AAF0AA,
    32'h0000FFFF, 32'hFFFF0000, 32'h7FFFFFFE, 32'h12345678
  };

  localparam logic [47:0] DirKey [DirectedItems] = '{
    48'h000000000000, 48'hFFFFFFFFFFFF, 48'hFFFFFFFFFFFF, 48'h000000000000,
    48'h861861861861, 48'h79E79E79E79E, 48'h000000000000, 48'hFFFFFFFFFFFF,
    48'h800000000001, 48'h000000000000, 48'hFFFFFFFFFFFF, 48'h1B02EFFC7072,
    48'hAAAAAAAAAAAA, 48'h555555555555, 48'h800000000000, 48'h000000000001
  };

  typedef enum logic [1:0] {
    StallNone,
    StallRandom,
    StallPeriodic,
    StallHeavy
  } stall_mode_e;

  typedef struct packed {
    logic [31:0] right_half;
    logic [47:0] round_key;
    logic [31:0] f_result;
  } round_beat_t;

  function automatic logic [31:0] des_f(input logic [31:0] r, input logic [47:0] k);
    logic [33:0] r_ext;
    logic [5:0]  grp;
    logic [63:0] row_bits;
    logic [31:0] sbox_word;
    logic [31:0] perm_word;
    // E wraps: group n reads DES bits 4n..4n+5, with bit 0 meaning 32 and 33 meaning 1
    r_ext = {r[0], r, r[31]};
    for (int n = 0; n < 8; n++) begin
      grp = r_ext[33 - 4*n -: 6] ^ k[47 - 6*n -: 6];
      row_bits = SboxRows[4*n + int'({grp[5], grp[0]})];
      sbox_word[31 - 4*n -: 4] = row_bits[63 - 4*int'(grp[4:1]) -: 4];
    end
    for (int i = 0; i < 32; i++) begin
      perm_word[31 - i] = sbox_word[32 - PermSrc[i]];
    end
    return perm_word;
  endfunction

  class f_result_scoreboard;
    round_beat_t f_results_due[$];
    int unsigned mismatches;

    function void note_round_input(input logic [31:0] r, input logic [47:0] k);
      round_beat_t b;
      b.right_half = r;
      b.round_key  = k;
      b.f_result   = des_f(r, k);
      f_results_due = {f_results_due, b};
    endfunction

    function void check_f_result(input logic [31:0] got);
      round_beat_t want;
      if (f_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported) begin
          $display("%0t: f_result %h with no beat outstanding", $realtime, got);
        end
        return;
      end
      want = f_results_due.pop_front();
      if (got !== want.f_result) begin
        mismatches++;
        if (mismatches <= MaxReported) begin
          $display("%0t: f_result mismatch for right_half %h round_key %h: expected %h, got %h",
                   $realtime, want.right_half, want.round_key, want.f_result, got);
        end
      end
    endfunction

    function int unsigned results_due();
      return f_results_due.size();
    endfunction
  endclass

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [31:0] right_half_i = '0;
  logic [47:0] round_key_i  = '0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [31:0] f_result_o;

  f_result_scoreboard sb = new;

  stall_mode_e stall_mode = StallNone;
  int unsigned stall_left = 0;
  int unsigned stall_tick = 0;

  des_round_function_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .right_half_i(right_half_i),
    .round_key_i (round_key_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .f_result_o  (f_result_o)
  );

  always #6 clk_i = ~clk_i;

  // Both channels sampled with pre-edge values; every driver uses nonblocking updates
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.note_round_input(right_half_i, round_key_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_f_result(f_result_o);
    end
  end

  // Receiver back-pressure: switches between stall patterns every so often
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      StallNone:     out_stall_i <= 1'b0;
      StallRandom:   out_stall_i <= ($urandom_range(0, 1) == 1);
      StallPeriodic: out_stall_i <= ((stall_tick % 5) < 2);
      default:       out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Called at a rising edge; returns at the edge where the beat is taken
  task automatic send_beat(input logic [31:0] r, input logic [47:0] k);
    in_valid_i   <= 1'b1;
    right_half_i <= r;
    round_key_i  <= k;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic idle_for(input int unsigned cycles);
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    in_valid_i   <= 1'b0;
    right_half_i <= noise[63:32];
    round_key_i  <= noise[47:0];
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.results_due() != 0);
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    int unsigned pick;
    int unsigned next_drain;
    logic [63:0] raw;
    logic [31:0] r;
    logic [47:0] k;

    // Sanity of the predictor against the published first-round example
    if (des_f(32'hF0AAF0AA, 48'h1B02EFFC7072) !== 32'h234AA9BB) begin
      $display("predictor disagrees with the known first-round value");
      sb.mismatches++;
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: back to back, no gaps
    for (int i = 0; i < DirectedItems; i++) begin
      send_beat(DirRight[i], DirKey[i]);
    end
    wait_all_results();

    sent = 0;
    next_drain = $urandom_range(300, 700);
    while (sent < RandomItems) begin
      burst = $urandom_range(1, 48);
      for (int i = 0; i < burst && sent < RandomItems; i++) begin
        raw  = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        r = raw[63:32];
        k = 48'({$urandom, $urandom});
        if (pick >= 70 && pick < 80) begin
          k = '0;
        end else if (pick >= 80 && pick < 88) begin
          k = '1;
        end else if (pick >= 88 && pick < 94) begin
          case (raw[1:0])
            2'd0: r = '0;
            2'd1: r = '1;
            2'd2: r = 32'h55555555;
            default: r = 32'hAAAAAAAA;
          endcase
        end else if (pick >= 94) begin
          // sparse: single set bits, exercises the duplicated E-table bits
          r = 32'h1 << raw[4:0];
          if (raw[5]) begin
            k = 48'h1 << $urandom_range(0, 47);
          end
        end
        send_beat(r, k);
        sent++;
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        gap = 0;
      end else if (pick < 93) begin
        gap = $urandom_range(1, 4);
      end else begin
        gap = $urandom_range(8, 24);
      end
      if (gap != 0) begin
        idle_for(gap);
      end
      if (sent >= next_drain) begin
        wait_all_results();
        next_drain = next_drain + $urandom_range(300, 700);
      end
    end

    wait_all_results();
    repeat (10) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.results_due() == 0) begin
      $display("des_round_function_unit test passed");
    end else begin
      $display("des_round_function_unit test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("des_round_function_unit test failed");
    $finish;
  end

endmodule

@@ des_round_function_unit.f @@
src/desrf_pkg.sv
src/desrf_expand.sv
src/desrf_sbox.sv
src/desrf_perm.sv
src/des_round_function_unit.sv
src/desrf_checker.sv
test/des_round_function_unit_test.sv
